// ===== rtl/sfr_pkg.sv =====
// sfr_pkg: shared types and constants of the stream find-and-replace block
// no dependencies; imported by sfr_cfg_if and all modules but sfr_checker
package sfr_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 8;
  localparam int unsigned MAX_RESULTS     = 8;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned TEXT_W          = 64;
  localparam int unsigned CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } cfg_reg_e;

  typedef struct packed {
    logic [TEXT_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]  pattern_length;
    logic [TEXT_W-1:0] replacement_bytes;
    logic [LEN_W-1:0]  replacement_length;
  } sfr_cfg_t;

  typedef struct packed {
    logic                        load;
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [LEN_W-1:0]            cnt;
    logic                        last;
    logic                        bare;
  } sfr_burst_t;

endpackage

// ===== rtl/sfr_if.sv =====
// sfr_in_if, sfr_out_if, sfr_cfg_if: valid/ready channels of the block
// depends on sfr_pkg
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, data_byte, end_of_text, input ready);
  modport sink (input valid, data_byte, end_of_text, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;

  modport source (output valid, out_byte, byte_valid, out_last, input ready);
  modport sink (input valid, out_byte, byte_valid, out_last, output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TEXT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sfr_cfg_regs.sv =====
// sfr_cfg_regs: configuration register file with length clamping
// depends on sfr_pkg and sfr_cfg_if
module sfr_cfg_regs import sfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfr_cfg_if.sink       cfg_i,
  output sfr_cfg_t      cfg_o
);

  logic [TEXT_W-1:0] pattern_bytes_q;
  logic [LEN_W-1:0]  pattern_length_q;
  logic [TEXT_W-1:0] replacement_bytes_q;
  logic [LEN_W-1:0]  replacement_length_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q      <= '0;
      pattern_length_q     <= LEN_W'(1);
      replacement_bytes_q  <= '0;
      replacement_length_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_i.data;
        REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_i.data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_i.data;
        REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.pattern_bytes     = pattern_bytes_q;
    cfg_o.replacement_bytes = replacement_bytes_q;
    if (pattern_length_q == '0) begin
      cfg_o.pattern_length = LEN_W'(1);
    end else if (pattern_length_q > LEN_W'(MAX_PATTERN)) begin
      cfg_o.pattern_length = LEN_W'(MAX_PATTERN);
    end else begin
      cfg_o.pattern_length = pattern_length_q;
    end
    if (replacement_length_q > LEN_W'(MAX_RESULTS)) begin
      cfg_o.replacement_length = LEN_W'(MAX_RESULTS);
    end else begin
      cfg_o.replacement_length = replacement_length_q;
    end
  end

endmodule

// ===== rtl/sfr_step.sv =====
// sfr_step: input register, match window and per-byte rewrite logic
// depends on sfr_pkg and sfr_in_if
module sfr_step import sfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfr_in_if.sink     in_i,
  input  sfr_cfg_t   cfg_i,
  input  logic       load_ok_i,
  output sfr_burst_t burst_o
);

  localparam int unsigned FW = $clog2(MAX_PATTERN);
  localparam int unsigned WD = MAX_PATTERN - 1;

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          in_eot_q;
  logic [7:0]    win_q [WD];
  logic [7:0]    win_d [WD];
  logic [FW-1:0] fill_q;
  logic [FW-1:0] fill_d;

  logic [7:0]       ext [MAX_PATTERN];
  logic [LEN_W-1:0] fill_ext;
  logic [LEN_W-1:0] nxt_cnt;
  logic [LEN_W-1:0] keep_max;
  logic [LEN_W-1:0] drop;
  logic [LEN_W-1:0] keep;
  logic             mism;
  logic             match;
  logic             step;

  assign step       = in_valid_q && load_ok_i;
  assign in_i.ready = !in_valid_q || load_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_eot_q  <= in_i.end_of_text;
    end
  end

  // extended window: held bytes then the new byte
  always_comb begin
    fill_ext = {{(LEN_W-FW){1'b0}}, fill_q};
    for (int j = 0; j < WD; j++) begin
      ext[j] = (LEN_W'(j) < fill_ext) ? win_q[j] : in_byte_q;
    end
    ext[WD] = in_byte_q;

    mism = 1'b0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (LEN_W'(j) <= fill_ext && ext[j] != cfg_i.pattern_bytes[8*j +: 8]) begin
        mism = 1'b1;
      end
    end
    nxt_cnt  = fill_ext + LEN_W'(1);
    match    = (nxt_cnt == cfg_i.pattern_length) && !mism;
    keep_max = cfg_i.pattern_length - LEN_W'(1);
    drop     = (nxt_cnt > keep_max) ? nxt_cnt - keep_max : '0;
    keep     = nxt_cnt - drop;

    for (int j = 0; j < WD; j++) begin
      win_d[j] = ext[j];
      for (int m = 0; m < MAX_PATTERN; m++) begin
        if (LEN_W'(m) == LEN_W'(j) + drop) begin
          win_d[j] = ext[m];
        end
      end
    end
  end

  always_comb begin
    burst_o.load  = step;
    burst_o.bytes = '0;
    burst_o.cnt   = '0;
    burst_o.last  = in_eot_q;
    burst_o.bare  = 1'b0;
    fill_d        = '0;
    if (match) begin
      for (int j = 0; j < MAX_RESULTS; j++) begin
        burst_o.bytes[j] = cfg_i.replacement_bytes[8*j +: 8];
      end
      burst_o.cnt = cfg_i.replacement_length;
      if (in_eot_q && cfg_i.replacement_length == '0) begin
        burst_o.cnt      = LEN_W'(1);
        burst_o.bare     = 1'b1;
        burst_o.bytes[0] = '0;
      end
    end else begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        burst_o.bytes[j] = ext[j];
      end
      if (in_eot_q) begin
        burst_o.cnt = nxt_cnt;
      end else begin
        burst_o.cnt = drop;
        fill_d      = keep[FW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (step) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      win_q <= win_d;
    end
  end

endmodule

// ===== rtl/sfr_result_buf.sv =====
// sfr_result_buf: result register that hands out one result beat per cycle while the output is ready
// depends on sfr_pkg and sfr_out_if
module sfr_result_buf import sfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sfr_burst_t burst_i,
  output logic       load_ok_o,
  sfr_out_if.source  out_o
);

  logic [MAX_RESULTS-1:0][7:0] bytes_q;
  logic [LEN_W-1:0]            cnt_q;
  logic                        last_q;
  logic                        bare_q;
  logic                        beat;

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.out_byte   = bytes_q[0];
  assign out_o.byte_valid = !bare_q;
  assign out_o.out_last   = last_q && (cnt_q == LEN_W'(1));
  assign beat             = out_o.valid && out_o.ready;
  assign load_ok_o        = (cnt_q == '0) || ((cnt_q == LEN_W'(1)) && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
      bare_q <= 1'b0;
    end else if (burst_i.load) begin
      cnt_q  <= burst_i.cnt;
      last_q <= burst_i.last;
      bare_q <= burst_i.bare;
    end else if (beat) begin
      cnt_q <= cnt_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_i.load) begin
      bytes_q <= burst_i.bytes;
    end else if (beat) begin
      bytes_q <= {8'h00, bytes_q[MAX_RESULTS-1:1]};
    end
  end

endmodule

// ===== rtl/stream_find_replace_core.sv =====
// Streaming find-and-replace over a byte text, one byte per input beat.
// An accepted byte waits in the input register, where it is
// compared against the held window and the pattern, and its results are
// loaded into the result register; from there one result leaves per cycle
// while the output is ready. While bytes yield zero or one result and
// the output is ready, the block takes one byte per cycle; a byte that
// yields n results (a replacement longer than one byte, or the flush on
// end_of_text) holds the result register until all n, up to 8, have left.
// Depends on sfr_pkg, the sfr interfaces, sfr_cfg_regs, sfr_step and
// sfr_result_buf.
module stream_find_replace_core import sfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfr_cfg_if.sink   cfg_i,
  sfr_in_if.sink    in_i,
  sfr_out_if.source out_o
);

  sfr_cfg_t   cfg;
  sfr_burst_t burst;
  logic       load_ok;

  sfr_cfg_regs #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg_regs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  sfr_step #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg),
    .load_ok_i(load_ok),
    .burst_o  (burst)
  );

  sfr_result_buf u_result_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .burst_i  (burst),
    .load_ok_o(load_ok),
    .out_o    (out_o)
  );

endmodule

// ===== rtl/sfr_checker.sv =====
// sfr_checker: port-level assertions on the result channel of the block
// bound to stream_find_replace_core; no package dependency
module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       out_last
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(byte_valid) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !byte_valid |-> out_last)
    else $error("empty result without end mark");

  a_bare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !byte_valid |-> out_byte == 8'h00)
    else $error("empty result carries a nonzero byte");

endmodule

bind stream_find_replace_core sfr_checker u_sfr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_byte  (out_o.out_byte),
  .byte_valid(out_o.byte_valid),
  .out_last  (out_o.out_last)
);
